// ===== sv/gppt_pkg.sv =====
// Shared types, codes and the fixed transition table of the phase decoder.
`default_nettype none

package gppt_pkg;

   // Phase codes.
   localparam logic [2:0] PH_IDLE         = 3'd0;
   localparam logic [2:0] PH_PREPARING    = 3'd1;
   localparam logic [2:0] PH_ANTICIPATING = 3'd2;
   localparam logic [2:0] PH_FORMING      = 3'd3;
   localparam logic [2:0] PH_HOLDING      = 3'd4;
   localparam logic [2:0] PH_RETURNING    = 3'd5;
   localparam logic [2:0] PH_DISSIPATING  = 3'd6;

   // Trigger codes.
   localparam logic [2:0] TR_START     = 3'd0;
   localparam logic [2:0] TR_ADVANCE   = 3'd1;
   localparam logic [2:0] TR_TIMEOUT   = 3'd2;
   localparam logic [2:0] TR_CANCEL    = 3'd3;
   localparam logic [2:0] TR_RETREAT   = 3'd4;
   localparam logic [2:0] TR_READY     = 3'd5;
   localparam logic [2:0] TR_MORPH     = 3'd6;
   localparam logic [2:0] TR_DISSIPATE = 3'd7;

   // Action codes.
   localparam logic [2:0] ACT_NONE      = 3'd0;
   localparam logic [2:0] ACT_BEGIN     = 3'd1;
   localparam logic [2:0] ACT_ENTER     = 3'd2;
   localparam logic [2:0] ACT_COMPLETE  = 3'd3;
   localparam logic [2:0] ACT_RETURN    = 3'd4;
   localparam logic [2:0] ACT_DISSIPATE = 3'd5;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_MANUAL    = 3'd0;
   localparam logic [2:0] REG_SKIP      = 3'd1;
   localparam logic [2:0] REG_FORM      = 3'd2;
   localparam logic [2:0] REG_HOLD      = 3'd3;
   localparam logic [2:0] REG_RETURN    = 3'd4;
   localparam logic [2:0] REG_DISSIPATE = 3'd5;

   localparam logic [15:0] MinTimeoutMs      = 16'd100;
   localparam logic [15:0] FormResetMs       = 16'd1000;
   localparam logic [15:0] ReturnResetMs     = 16'd1000;
   localparam logic [15:0] DissipateResetMs  = 16'd1000;

   // Guard kinds of the table rows.
   typedef enum logic [3:0] {
      G_ALWAYS, G_NOT_MANUAL, G_MANUAL, G_MASK_READY, G_MAN_AWAIT, G_AWAIT_AUTO,
      G_READY_AUTO, G_FORM_TO, G_HOLD_TO, G_RET_TO, G_DIS_TO, G_SKIP_CANCEL,
      G_NEED_RETURN, G_TARGETS, G_SKIP_FLAG
   } guard_type;

   typedef struct packed {
      logic [2:0] from_phase;
      logic [2:0] trig;
      guard_type  guard;
      logic [2:0] action;
      logic [2:0] to_phase;
      logic       clr;
   } row_type;

   // Condition flags worked out in the first stage.
   typedef struct packed {
      logic [2:0] phase;
      logic [2:0] trig;
      logic       man;
      logic       pend;
      logic       ready;
      logic       targets;
      logic       skip;
      logic       skip_flag;
      logic       form_to;
      logic       hold_to;
      logic       ret_to;
      logic       dis_to;
   } flags_type;

   localparam int RowCount = 37;

   // Rows in priority order: the first match wins.
   localparam row_type RowTable [RowCount] = '{
      '{PH_IDLE, TR_START, G_NOT_MANUAL, ACT_BEGIN, PH_ANTICIPATING, 1'b0},
      '{PH_IDLE, TR_START, G_MANUAL, ACT_BEGIN, PH_FORMING, 1'b0},
      '{PH_IDLE, TR_ADVANCE, G_NOT_MANUAL, ACT_BEGIN, PH_ANTICIPATING, 1'b0},
      '{PH_IDLE, TR_ADVANCE, G_MANUAL, ACT_BEGIN, PH_FORMING, 1'b0},
      '{PH_PREPARING, TR_TIMEOUT, G_NOT_MANUAL, ACT_ENTER, PH_ANTICIPATING, 1'b0},
      '{PH_PREPARING, TR_ADVANCE, G_MAN_AWAIT, ACT_NONE, PH_PREPARING, 1'b0},
      '{PH_PREPARING, TR_ADVANCE, G_MASK_READY, ACT_ENTER, PH_FORMING, 1'b1},
      '{PH_PREPARING, TR_CANCEL, G_SKIP_CANCEL, ACT_COMPLETE, PH_IDLE, 1'b0},
      '{PH_PREPARING, TR_RETREAT, G_ALWAYS, ACT_COMPLETE, PH_IDLE, 1'b0},
      '{PH_ANTICIPATING, TR_ADVANCE, G_AWAIT_AUTO, ACT_NONE, PH_ANTICIPATING, 1'b0},
      '{PH_ANTICIPATING, TR_ADVANCE, G_MASK_READY, ACT_ENTER, PH_FORMING, 1'b1},
      '{PH_ANTICIPATING, TR_READY, G_READY_AUTO, ACT_ENTER, PH_FORMING, 1'b1},
      '{PH_ANTICIPATING, TR_CANCEL, G_SKIP_CANCEL, ACT_COMPLETE, PH_IDLE, 1'b0},
      '{PH_ANTICIPATING, TR_RETREAT, G_ALWAYS, ACT_COMPLETE, PH_IDLE, 1'b0},
      '{PH_FORMING, TR_ADVANCE, G_ALWAYS, ACT_ENTER, PH_HOLDING, 1'b0},
      '{PH_FORMING, TR_TIMEOUT, G_FORM_TO, ACT_ENTER, PH_HOLDING, 1'b0},
      '{PH_FORMING, TR_RETREAT, G_MANUAL, ACT_COMPLETE, PH_IDLE, 1'b0},
      '{PH_FORMING, TR_RETREAT, G_NOT_MANUAL, ACT_ENTER, PH_ANTICIPATING, 1'b0},
      '{PH_HOLDING, TR_ADVANCE, G_ALWAYS, ACT_RETURN, PH_RETURNING, 1'b0},
      '{PH_HOLDING, TR_TIMEOUT, G_HOLD_TO, ACT_RETURN, PH_RETURNING, 1'b0},
      '{PH_HOLDING, TR_MORPH, G_TARGETS, ACT_ENTER, PH_FORMING, 1'b1},
      '{PH_HOLDING, TR_RETREAT, G_ALWAYS, ACT_ENTER, PH_FORMING, 1'b0},
      '{PH_HOLDING, TR_CANCEL, G_NEED_RETURN, ACT_RETURN, PH_RETURNING, 1'b0},
      '{PH_RETURNING, TR_ADVANCE, G_ALWAYS, ACT_COMPLETE, PH_IDLE, 1'b0},
      '{PH_RETURNING, TR_TIMEOUT, G_RET_TO, ACT_COMPLETE, PH_IDLE, 1'b0},
      '{PH_RETURNING, TR_RETREAT, G_ALWAYS, ACT_ENTER, PH_HOLDING, 1'b0},
      '{PH_RETURNING, TR_DISSIPATE, G_ALWAYS, ACT_DISSIPATE, PH_DISSIPATING, 1'b0},
      '{PH_DISSIPATING, TR_ADVANCE, G_ALWAYS, ACT_COMPLETE, PH_IDLE, 1'b0},
      '{PH_DISSIPATING, TR_TIMEOUT, G_DIS_TO, ACT_COMPLETE, PH_IDLE, 1'b0},
      '{PH_DISSIPATING, TR_RETREAT, G_ALWAYS, ACT_ENTER, PH_HOLDING, 1'b0},
      '{PH_FORMING, TR_CANCEL, G_SKIP_FLAG, ACT_COMPLETE, PH_IDLE, 1'b0},
      '{PH_HOLDING, TR_CANCEL, G_SKIP_FLAG, ACT_COMPLETE, PH_IDLE, 1'b0},
      '{PH_RETURNING, TR_CANCEL, G_SKIP_FLAG, ACT_COMPLETE, PH_IDLE, 1'b0},
      '{PH_DISSIPATING, TR_CANCEL, G_SKIP_FLAG, ACT_COMPLETE, PH_IDLE, 1'b0},
      '{PH_FORMING, TR_CANCEL, G_NEED_RETURN, ACT_RETURN, PH_RETURNING, 1'b0},
      '{PH_RETURNING, TR_CANCEL, G_NEED_RETURN, ACT_RETURN, PH_RETURNING, 1'b0},
      '{PH_DISSIPATING, TR_CANCEL, G_NEED_RETURN, ACT_COMPLETE, PH_IDLE, 1'b0}
   };

   // Duration with the minimum timeout applied.
   function automatic logic [15:0] floor_ms(input logic [15:0] dur);
      floor_ms = (dur < MinTimeoutMs) ? MinTimeoutMs : dur;
   endfunction

   // Evaluates one guard kind against the precomputed flags.
   function automatic logic guard_holds(input guard_type g, input flags_type f);
      logic res;
      res = 1'b0;
      case (g)
         G_ALWAYS:      res = 1'b1;
         G_NOT_MANUAL:  res = !f.man;
         G_MANUAL:      res = f.man;
         G_MASK_READY:  res = f.ready;
         G_MAN_AWAIT:   res = f.man && f.pend;
         G_AWAIT_AUTO:  res = f.pend && !f.man;
         G_READY_AUTO:  res = !f.man && f.ready;
         G_FORM_TO:     res = !f.man && f.form_to;
         G_HOLD_TO:     res = !f.man && f.hold_to;
         G_RET_TO:      res = f.ret_to;
         G_DIS_TO:      res = !f.man && f.dis_to;
         G_SKIP_CANCEL: res = f.skip;
         G_NEED_RETURN: res = !f.skip;
         G_TARGETS:     res = f.targets;
         G_SKIP_FLAG:   res = f.skip_flag;
         default:       res = 1'b0;
      endcase
      guard_holds = res;
   endfunction

endpackage

`default_nettype wire

// ===== sv/gppt_rows.sv =====
// Second pipeline stage: matches every table row against the flags of one beat.
`default_nettype none

module gppt_rows (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          s1_valid,
   input  wire gppt_pkg::flags_type           s1_flags,
   output logic                               s2_valid,
   output logic [gppt_pkg::RowCount-1:0]      s2_match
);
   import gppt_pkg::*;

   logic                s2_valid_ff;
   logic [RowCount-1:0] s2_match_ff;
   logic [RowCount-1:0] s2_match_in;

   // One match bit per row: phase, trigger and guard all agree.
   always_comb begin
      for (int r = 0; r < RowCount; r++) begin
         s2_match_in[r] = (RowTable[r].from_phase == s1_flags.phase) &&
                          (RowTable[r].trig == s1_flags.trig) &&
                          guard_holds(RowTable[r].guard, s1_flags);
      end
   end

   // Stage register; the valid bit travels with the match vector.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid;
      end
      s2_match_ff <= s2_match_in;
   end

   assign s2_valid = s2_valid_ff;
   assign s2_match = s2_match_ff;

endmodule

`default_nettype wire

// ===== sv/guarded_pattern_phase_transition.sv =====
// Top level of the guarded phase transition decoder with its register file.
//
//   Channel   Ports                                   Handshake
//   request   start, busy, req_*                      beat taken when start && !busy
//   response  rsp_valid, rsp_*                        one-cycle strobe, never held off
//   config    psel, penable, pwrite, paddr, pwdata,   APB write, pready tied high
//             prdata, pready
//
// Each beat passes three register stages (flags, row match, priority pick). Its result
// shows on rsp_valid once the priority pick register has captured it. A new beat may be
// taken every cycle and busy stays low. Reset clears the stage valid bits and loads the
// register defaults. Since the receiver cannot stall, the pipeline never stops.
`default_nettype none

module guarded_pattern_phase_transition (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_current_phase,
   input  wire logic [2:0]  req_trigger_kind,
   input  wire logic        req_mask_pending,
   input  wire logic [15:0] req_target_count,
   input  wire logic [15:0] req_elapsed_ms,
   output logic             rsp_valid,
   output logic             rsp_handled,
   output logic [2:0]       rsp_action_code,
   output logic [2:0]       rsp_next_phase,
   output logic             rsp_clear_start_log,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import gppt_pkg::*;

   logic        manual_ff;
   logic        skip_ff;
   logic [15:0] form_ff;
   logic [15:0] hold_ff;
   logic [15:0] return_ff;
   logic [15:0] dissipate_ff;
   logic        csr_write;
   logic [2:0]  csr_index;

   logic        accept;
   flags_type   s1_flags_in;
   flags_type   s1_flags_ff;
   logic        s1_valid_ff;

   logic                s2_valid;
   logic [RowCount-1:0] s2_match;

   logic        rsp_valid_ff;
   logic        rsp_handled_ff;
   logic        rsp_handled_in;
   logic [2:0]  rsp_action_ff;
   logic [2:0]  rsp_action_in;
   logic [2:0]  rsp_next_ff;
   logic [2:0]  rsp_next_in;
   logic        rsp_clear_ff;
   logic        rsp_clear_in;

   // Register file: write on the access cycle, reads are plain muxing.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         manual_ff    <= 1'b0;
         skip_ff      <= 1'b0;
         form_ff      <= FormResetMs;
         hold_ff      <= 16'd0;
         return_ff    <= ReturnResetMs;
         dissipate_ff <= DissipateResetMs;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MANUAL:    manual_ff    <= pwdata[0];
            REG_SKIP:      skip_ff      <= pwdata[0];
            REG_FORM:      form_ff      <= pwdata[15:0];
            REG_HOLD:      hold_ff      <= pwdata[15:0];
            REG_RETURN:    return_ff    <= pwdata[15:0];
            REG_DISSIPATE: dissipate_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_MANUAL:    prdata = {31'd0, manual_ff};
         REG_SKIP:      prdata = {31'd0, skip_ff};
         REG_FORM:      prdata = {16'd0, form_ff};
         REG_HOLD:      prdata = {16'd0, hold_ff};
         REG_RETURN:    prdata = {16'd0, return_ff};
         REG_DISSIPATE: prdata = {16'd0, dissipate_ff};
         default:       prdata = 32'd0;
      endcase
   end

   // The pipeline never backs up, so a beat is taken whenever start is high.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Stage one: the timing compares and the other guard conditions.
   always_comb begin
      s1_flags_in.phase     = req_current_phase;
      s1_flags_in.trig      = req_trigger_kind;
      s1_flags_in.man       = manual_ff;
      s1_flags_in.pend      = req_mask_pending;
      s1_flags_in.targets   = (req_target_count != 16'd0);
      s1_flags_in.ready     = !req_mask_pending && (req_target_count != 16'd0);
      s1_flags_in.skip_flag = skip_ff;
      s1_flags_in.skip      = skip_ff || (req_current_phase == PH_ANTICIPATING) ||
                              (req_current_phase == PH_PREPARING);
      s1_flags_in.form_to   = (req_elapsed_ms >= floor_ms(form_ff));
      s1_flags_in.hold_to   = (hold_ff != 16'd0) && (req_elapsed_ms >= hold_ff);
      s1_flags_in.ret_to    = (req_elapsed_ms >= floor_ms(return_ff));
      s1_flags_in.dis_to    = (req_elapsed_ms >= floor_ms(dissipate_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_flags_ff <= s1_flags_in;
   end

   // Stage two: row matching.
   gppt_rows u_rows (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid_ff),
      .s1_flags (s1_flags_ff),
      .s2_valid (s2_valid),
      .s2_match (s2_match)
   );

   // Stage three: the lowest matching row wins; no match gives all zeros.
   always_comb begin
      rsp_handled_in = 1'b0;
      rsp_action_in  = ACT_NONE;
      rsp_next_in    = PH_IDLE;
      rsp_clear_in   = 1'b0;
      for (int r = RowCount - 1; r >= 0; r--) begin
         if (s2_match[r]) begin
            rsp_handled_in = 1'b1;
            rsp_action_in  = RowTable[r].action;
            rsp_next_in    = RowTable[r].to_phase;
            rsp_clear_in   = RowTable[r].clr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid;
      end
      rsp_handled_ff <= rsp_handled_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_next_ff    <= rsp_next_in;
      rsp_clear_ff   <= rsp_clear_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_handled         = rsp_handled_ff;
   assign rsp_action_code     = rsp_action_ff;
   assign rsp_next_phase      = rsp_next_ff;
   assign rsp_clear_start_log = rsp_clear_ff;

endmodule

`default_nettype wire
